// ----- sv/multi_run_target_crossing_search_core_macros.svh -----
// Assertion macros used by the checker file of the crossing search core.
`ifndef MULTI_RUN_TARGET_CROSSING_SEARCH_CORE_MACROS_SVH
`define MULTI_RUN_TARGET_CROSSING_SEARCH_CORE_MACROS_SVH

// Checked outside reset only.
`define MRTCS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every edge, reset included.
`define MRTCS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/mrtcs_pkg.sv -----
// Types and constants of the multi-run target crossing search core.
package mrtcs_pkg;

    localparam int EVALS_W     = 48;
    localparam int VALUE_W     = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int MAX_RESULTS = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_RUNS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EVAL_COL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COL = 2'd2;

    localparam logic [5:0] NUM_RUNS_RST   = 6'd1;
    localparam logic [7:0] EVAL_COL_RST   = 8'd0;
    localparam logic [7:0] TARGET_COL_RST = 8'd1;

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_REWIND = 2'd1,
        REQ_QUERY  = 2'd2
    } req_code_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_RD,
        ST_LOAD_WR,
        ST_REWIND,
        ST_RUN_RD,
        ST_RUN_GET,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic               [1:0] req_type;
        logic               [4:0] run_index;
        logic               [9:0] row_index;
        logic               [7:0] column_index;
        logic signed [VALUE_W-1:0] cell_value;
        logic signed [VALUE_W-1:0] threshold;
    } in_item_t;

    typedef struct packed {
        logic         [4:0] out_run;
        logic [EVALS_W-1:0] evals_found;
        logic               result_present;
        logic               last_result;
    } out_item_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear_state;
    } run_ctl_t;

    typedef struct packed {
        logic rd_en;
        logic we_evals;
        logic we_target;
    } store_ctl_t;

endpackage

// ----- sv/mrtcs_row_store.sv -----
// Row store: evaluation counts and target values of all runs, one read and one write port.
module mrtcs_row_store #(
    parameter int ADDR_W = 15,
    parameter int DEPTH  = 32768
) (
    input  logic                                    aclk,
    input  mrtcs_pkg::store_ctl_t                   ctl,
    input  logic [ADDR_W-1:0]                       wr_addr,
    input  logic [mrtcs_pkg::EVALS_W-1:0]           wr_evals,
    input  logic signed [mrtcs_pkg::VALUE_W-1:0]    wr_target,
    input  logic [ADDR_W-1:0]                       rd_addr,
    output logic [mrtcs_pkg::EVALS_W-1:0]           rd_evals,
    output logic signed [mrtcs_pkg::VALUE_W-1:0]    rd_target
);

    logic [mrtcs_pkg::EVALS_W-1:0]        evals_mem  [DEPTH];
    logic signed [mrtcs_pkg::VALUE_W-1:0] target_mem [DEPTH];
    logic [mrtcs_pkg::EVALS_W-1:0]        rd_evals_reg;
    logic signed [mrtcs_pkg::VALUE_W-1:0] rd_target_reg;

    always_ff @(posedge aclk) begin
        if (ctl.we_evals) begin
            evals_mem[wr_addr] <= wr_evals;
        end
        if (ctl.we_target) begin
            target_mem[wr_addr] <= wr_target;
        end
        if (ctl.rd_en) begin
            rd_evals_reg  <= evals_mem[rd_addr];
            rd_target_reg <= target_mem[rd_addr];
        end
    end

    assign rd_evals  = rd_evals_reg;
    assign rd_target = rd_target_reg;

endmodule

// ----- sv/mrtcs_run_table.sv -----
// Per-run table: row count, cursor and held result, with valid bits for reset and rewind.
module mrtcs_run_table #(
    parameter int RUNS  = 32,
    parameter int RUN_W = 5,
    parameter int ROW_W = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mrtcs_pkg::run_ctl_t           ctl,
    input  logic [RUN_W-1:0]              rd_addr,
    input  logic [RUN_W-1:0]              wr_addr,
    input  logic [ROW_W:0]                wr_rc,
    input  logic [ROW_W-1:0]              wr_cursor,
    input  logic [mrtcs_pkg::EVALS_W-1:0] wr_held,
    input  logic                          wr_present,
    output logic [ROW_W:0]                rd_rc,
    output logic [ROW_W-1:0]              rd_cursor,
    output logic [mrtcs_pkg::EVALS_W-1:0] rd_held,
    output logic                          rd_present
);

    localparam int ENT_W = (ROW_W + 1) + ROW_W + mrtcs_pkg::EVALS_W + 1;

    logic [ENT_W-1:0]              run_mem [RUNS];
    logic [ENT_W-1:0]              rd_raw_reg;
    logic                          rc_ok_reg;
    logic                          st_ok_reg;
    logic [RUNS-1:0]               rc_valid_reg;
    logic [RUNS-1:0]               st_valid_reg;
    logic [ROW_W:0]                raw_rc;
    logic [ROW_W-1:0]              raw_cursor;
    logic [mrtcs_pkg::EVALS_W-1:0] raw_held;
    logic                          raw_present;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            run_mem[wr_addr] <= {wr_rc, wr_cursor, wr_held, wr_present};
        end
        if (ctl.rd_en) begin
            rd_raw_reg <= run_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rc_valid_reg <= '0;
            st_valid_reg <= '0;
            rc_ok_reg    <= 1'b0;
            st_ok_reg    <= 1'b0;
        end else begin
            if (ctl.clear_state) begin
                st_valid_reg <= '0;
            end else if (ctl.wr_en) begin
                rc_valid_reg[wr_addr] <= 1'b1;
                st_valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en) begin
                rc_ok_reg <= rc_valid_reg[rd_addr];
                st_ok_reg <= st_valid_reg[rd_addr];
            end
        end
    end

    assign {raw_rc, raw_cursor, raw_held, raw_present} = rd_raw_reg;

    assign rd_rc      = rc_ok_reg ? raw_rc      : '0;
    assign rd_cursor  = st_ok_reg ? raw_cursor  : '0;
    assign rd_held    = st_ok_reg ? raw_held    : '0;
    assign rd_present = st_ok_reg ? raw_present : 1'b0;

endmodule

// ----- sv/multi_run_target_crossing_search_core.sv -----
// Top level of the multi-run target crossing search core: request sequencer and result register.
// Load: run-table read, then row-count write-back unless the cell is dropped; rewind clears cursors.
// Query: per run, run table read, store scan (one store read per row scanned), then result;
//   a run with no rows skips the scan. The next result waits only while the output is full.
// Reset (aresetn low, synchronous) clears control and run-table valid bits and restores the
//   config defaults at once; the row store is not cleared and no request is held off after reset.
module multi_run_target_crossing_search_core #(
    parameter int RUNS = 32,
    parameter int ROWS = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  mrtcs_pkg::in_item_t                  s_item,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output mrtcs_pkg::out_item_t                 m_item,
    input  logic                                 cfg_we,
    input  logic [mrtcs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mrtcs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int RUN_W   = (RUNS > 1) ? $clog2(RUNS) : 1;
    localparam int ROW_W   = $clog2(ROWS);
    localparam int RC_W    = ROW_W + 1;
    localparam int ADDR_W  = RUN_W + ROW_W;
    localparam int DEPTH   = RUNS * (2 ** ROW_W);
    localparam int RUN_LIM = (RUNS < mrtcs_pkg::MAX_RESULTS) ? RUNS : mrtcs_pkg::MAX_RESULTS;

    mrtcs_pkg::state_t             state_reg, state_next;
    mrtcs_pkg::in_item_t           req_reg, req_next;
    logic [5:0]                    k_reg, k_next;
    logic [5:0]                    n_reg, n_next;
    logic [ROW_W-1:0]              cur_reg, cur_next;
    logic [RC_W-1:0]               rc_reg, rc_next;
    logic [mrtcs_pkg::EVALS_W-1:0] held_reg, held_next;
    logic                          pres_reg, pres_next;
    mrtcs_pkg::out_item_t          out_reg, out_next;
    logic                          out_valid_reg, out_valid_next;
    logic [5:0]                    num_runs_reg;
    logic [7:0]                    eval_col_reg;
    logic [7:0]                    target_col_reg;

    mrtcs_pkg::run_ctl_t           run_ctl;
    logic [RUN_W-1:0]              run_rd_addr;
    logic [RUN_W-1:0]              run_wr_addr;
    logic [RC_W-1:0]               run_wr_rc;
    logic [ROW_W-1:0]              run_wr_cursor;
    logic [mrtcs_pkg::EVALS_W-1:0] run_wr_held;
    logic                          run_wr_present;
    logic [RC_W-1:0]               run_rd_rc;
    logic [ROW_W-1:0]              run_rd_cursor;
    logic [mrtcs_pkg::EVALS_W-1:0] run_rd_held;
    logic                          run_rd_present;

    mrtcs_pkg::store_ctl_t         store_ctl;
    logic [ADDR_W-1:0]             store_rd_addr;
    logic [ADDR_W-1:0]             ld_addr;
    logic [mrtcs_pkg::EVALS_W-1:0] store_rd_evals;
    logic signed [mrtcs_pkg::VALUE_W-1:0] store_rd_target;

    logic                          ld_in_range;
    logic                          ld_eval_hit;
    logic                          ld_target_hit;
    logic [RC_W-1:0]               ld_row_end;
    logic [5:0]                    n_eff;
    logic [RC_W-1:0]               cur_inc;
    logic [5:0]                    k_inc;
    logic                          k_last;
    logic                          crossed;

    mrtcs_row_store #(
        .ADDR_W (ADDR_W),
        .DEPTH  (DEPTH)
    ) u_store (
        .aclk      (aclk),
        .ctl       (store_ctl),
        .wr_addr   (ld_addr),
        .wr_evals  (req_reg.cell_value[mrtcs_pkg::EVALS_W-1:0]),
        .wr_target (req_reg.cell_value),
        .rd_addr   (store_rd_addr),
        .rd_evals  (store_rd_evals),
        .rd_target (store_rd_target)
    );

    mrtcs_run_table #(
        .RUNS  (RUNS),
        .RUN_W (RUN_W),
        .ROW_W (ROW_W)
    ) u_runs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (run_ctl),
        .rd_addr    (run_rd_addr),
        .wr_addr    (run_wr_addr),
        .wr_rc      (run_wr_rc),
        .wr_cursor  (run_wr_cursor),
        .wr_held    (run_wr_held),
        .wr_present (run_wr_present),
        .rd_rc      (run_rd_rc),
        .rd_cursor  (run_rd_cursor),
        .rd_held    (run_rd_held),
        .rd_present (run_rd_present)
    );

    assign ld_addr       = {RUN_W'(req_reg.run_index), ROW_W'(req_reg.row_index)};
    assign ld_in_range   = (7'(req_reg.run_index) < 7'(RUNS))
                        && (17'(req_reg.row_index) < 17'(ROWS));
    assign ld_eval_hit   = ld_in_range && (req_reg.column_index == eval_col_reg);
    assign ld_target_hit = ld_in_range && (req_reg.column_index == target_col_reg);
    assign ld_row_end    = RC_W'(req_reg.row_index) + RC_W'(1);
    assign n_eff         = (num_runs_reg > 6'(RUN_LIM)) ? 6'(RUN_LIM) : num_runs_reg;
    assign cur_inc       = RC_W'(cur_reg) + RC_W'(1);
    assign k_inc         = k_reg + 6'd1;
    assign k_last        = (k_inc == n_reg);
    assign crossed       = ($signed(store_rd_target) >= $signed(req_reg.threshold));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_runs_reg   <= mrtcs_pkg::NUM_RUNS_RST;
            eval_col_reg   <= mrtcs_pkg::EVAL_COL_RST;
            target_col_reg <= mrtcs_pkg::TARGET_COL_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                mrtcs_pkg::CFG_NUM_RUNS:   num_runs_reg   <= cfg_wdata[5:0];
                mrtcs_pkg::CFG_EVAL_COL:   eval_col_reg   <= cfg_wdata;
                mrtcs_pkg::CFG_TARGET_COL: target_col_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mrtcs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            n_reg         <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg  <= req_next;
        cur_reg  <= cur_next;
        rc_reg   <= rc_next;
        held_reg <= held_next;
        pres_reg <= pres_next;
        out_reg  <= out_next;
    end

    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        cur_next       = cur_reg;
        rc_next        = rc_reg;
        held_next      = held_reg;
        pres_next      = pres_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        s_ready        = 1'b0;
        run_ctl        = '0;
        run_rd_addr    = RUN_W'(k_reg);
        run_wr_addr    = RUN_W'(k_reg);
        run_wr_rc      = rc_reg;
        run_wr_cursor  = cur_reg;
        run_wr_held    = held_reg;
        run_wr_present = pres_reg;
        store_ctl      = '0;
        store_rd_addr  = {RUN_W'(k_reg), cur_reg};

        unique case (state_reg)
            mrtcs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_next = s_item;
                    k_next   = '0;
                    n_next   = n_eff;
                    unique case (s_item.req_type)
                        mrtcs_pkg::REQ_LOAD:   state_next = mrtcs_pkg::ST_LOAD_RD;
                        mrtcs_pkg::REQ_REWIND: state_next = mrtcs_pkg::ST_REWIND;
                        mrtcs_pkg::REQ_QUERY: begin
                            if (n_eff != 6'd0) begin
                                state_next = mrtcs_pkg::ST_RUN_RD;
                            end
                        end
                        default: state_next = mrtcs_pkg::ST_IDLE;
                    endcase
                end
            end
            mrtcs_pkg::ST_LOAD_RD: begin
                store_ctl.we_evals  = ld_eval_hit;
                store_ctl.we_target = ld_target_hit;
                run_ctl.rd_en       = 1'b1;
                run_rd_addr         = RUN_W'(req_reg.run_index);
                if (ld_eval_hit || ld_target_hit) begin
                    state_next = mrtcs_pkg::ST_LOAD_WR;
                end else begin
                    state_next = mrtcs_pkg::ST_IDLE;
                end
            end
            mrtcs_pkg::ST_LOAD_WR: begin
                run_ctl.wr_en  = 1'b1;
                run_wr_addr    = RUN_W'(req_reg.run_index);
                run_wr_rc      = (ld_row_end > run_rd_rc) ? ld_row_end : run_rd_rc;
                run_wr_cursor  = run_rd_cursor;
                run_wr_held    = run_rd_held;
                run_wr_present = run_rd_present;
                state_next     = mrtcs_pkg::ST_IDLE;
            end
            mrtcs_pkg::ST_REWIND: begin
                run_ctl.clear_state = 1'b1;
                state_next          = mrtcs_pkg::ST_IDLE;
            end
            mrtcs_pkg::ST_RUN_RD: begin
                run_ctl.rd_en = 1'b1;
                state_next    = mrtcs_pkg::ST_RUN_GET;
            end
            mrtcs_pkg::ST_RUN_GET: begin
                cur_next  = run_rd_cursor;
                rc_next   = run_rd_rc;
                held_next = run_rd_held;
                pres_next = run_rd_present;
                if (run_rd_rc == '0) begin
                    state_next = mrtcs_pkg::ST_FINISH;
                end else begin
                    store_ctl.rd_en = 1'b1;
                    store_rd_addr   = {RUN_W'(k_reg), run_rd_cursor};
                    state_next      = mrtcs_pkg::ST_SCAN;
                end
            end
            mrtcs_pkg::ST_SCAN: begin
                if (crossed) begin
                    held_next  = store_rd_evals;
                    pres_next  = 1'b1;
                    state_next = mrtcs_pkg::ST_FINISH;
                end else if (cur_inc < rc_reg) begin
                    cur_next        = cur_inc[ROW_W-1:0];
                    store_ctl.rd_en = 1'b1;
                    store_rd_addr   = {RUN_W'(k_reg), cur_inc[ROW_W-1:0]};
                end else begin
                    state_next = mrtcs_pkg::ST_FINISH;
                end
            end
            mrtcs_pkg::ST_FINISH: begin
                if (!out_valid_reg || m_ready) begin
                    run_ctl.wr_en           = 1'b1;
                    out_valid_next          = 1'b1;
                    out_next.out_run        = k_reg[4:0];
                    out_next.evals_found    = held_reg;
                    out_next.result_present = pres_reg;
                    out_next.last_result    = k_last;
                    k_next                  = k_inc;
                    if (k_last) begin
                        state_next = mrtcs_pkg::ST_IDLE;
                    end else begin
                        state_next = mrtcs_pkg::ST_RUN_RD;
                    end
                end
            end
            default: state_next = mrtcs_pkg::ST_IDLE;
        endcase
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

endmodule

// ----- sv/mrtcs_checker.sv -----
// Port-level checker of the crossing search core, bound to the top level.
`include "multi_run_target_crossing_search_core_macros.svh"

module mrtcs_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input mrtcs_pkg::out_item_t m_item
);

    `MRTCS_ASSERT(a_result_held, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_item), "result changed or dropped while stalled")
    `MRTCS_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_valid, "result pending after reset")
    `MRTCS_ASSERT(a_idle_quiet, aclk, aresetn, s_ready && !m_valid |=> !m_valid, "result appeared one cycle after idle")
    `MRTCS_ASSERT(a_query_busy, aclk, aresetn, m_valid && !m_item.last_result |-> !s_ready, "request taken before query finished")

endmodule

bind multi_run_target_crossing_search_core mrtcs_checker u_mrtcs_checker (.*);
